// ----- hdl/talk_button_gesture_fsm_unit_defines.svh -----
// Assertion macros shared by the talk button gesture recognizer modules.
`ifndef TALK_BUTTON_GESTURE_FSM_UNIT_DEFINES_SVH
`define TALK_BUTTON_GESTURE_FSM_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and idle while reset is low.
`define TBG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and idle while reset is low.
`define TBG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tbg_pkg.sv -----
// Shared types and codes for the talk button gesture recognizer.
package tbg_pkg;

  // Effect codes reported in a result beat.
  typedef enum logic [2:0] {
    FX_NONE     = 3'd0,
    FX_START    = 3'd1,
    FX_STOP     = 3'd2,
    FX_LOCKED   = 3'd3,
    FX_UNLOCKED = 3'd4
  } fx_t;

  // Configuration register indexes.
  localparam logic REG_TAP_MAX       = 1'b0;
  localparam logic REG_SECOND_WINDOW = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [31:0] TAP_MAX_RESET       = 32'd300;
  localparam logic [31:0] SECOND_WINDOW_RESET = 32'd400;

  // One registered button sample with its precomputed second-tap deadline.
  typedef struct packed {
    logic        button_down;
    logic [63:0] time_ms;
    logic [63:0] deadline;
  } sample_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] fx_count;
    fx_t        first_effect;
    fx_t        second_effect;
    logic       talk_on;
    logic       hands_free;
  } result_t;

endpackage

// ----- hdl/tbg_gesture_core.sv -----
// Gesture phase machine: edge detection, tap timing and result register.
`include "talk_button_gesture_fsm_unit_defines.svh"

module tbg_gesture_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  tbg_pkg::sample_t  sample,
  input  logic [31:0]       tap_max_ms,
  output tbg_pkg::result_t  result
);
  import tbg_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE           = 3'd0,
    PH_FIRST_DOWN     = 3'd1,
    PH_WAIT_SECOND    = 3'd2,
    PH_SECOND_DOWN    = 3'd3,
    PH_LOCKED         = 3'd4,
    PH_LK_FIRST_DOWN  = 3'd5,
    PH_LK_WAIT_SECOND = 3'd6,
    PH_LK_SECOND_DOWN = 3'd7
  } phase_t;

  phase_t      phase_r, phase_mid, phase_nxt;
  logic        last_level_r;
  logic [63:0] press_start_r, press_start_nxt;
  logic [63:0] deadline_r, deadline_nxt;
  result_t     result_r, result_nxt;

  logic        press, release_edge;
  logic        deadline_hit;
  logic [63:0] elapsed;
  logic        short_tap;

  // Edges against the previous level, deadline and tap-length checks.
  assign press        = sample.button_down & ~last_level_r;
  assign release_edge = ~sample.button_down & last_level_r;
  assign deadline_hit = sample.time_ms >= deadline_r;
  assign elapsed      = sample.time_ms - press_start_r;
  assign short_tap    = (sample.time_ms >= press_start_r) && (elapsed[63:32] == 32'd0) &&
                        (elapsed[31:0] <= tap_max_ms);

  // Next phase and effects; an expired wait is resolved before edges are handled.
  always_comb begin
    phase_mid       = phase_r;
    press_start_nxt = press_start_r;
    deadline_nxt    = deadline_r;
    result_nxt.fx_count      = 2'd0;
    result_nxt.first_effect  = FX_NONE;
    result_nxt.second_effect = FX_NONE;

    if (phase_r == PH_WAIT_SECOND && deadline_hit) begin
      phase_mid = PH_IDLE;
      result_nxt.fx_count     = 2'd1;
      result_nxt.first_effect = FX_STOP;
    end else if (phase_r == PH_LK_WAIT_SECOND && deadline_hit) begin
      phase_mid = PH_LOCKED;
    end

    phase_nxt = phase_mid;
    case (phase_mid)
      PH_IDLE: begin
        if (press) begin
          press_start_nxt = sample.time_ms;
          phase_nxt       = PH_FIRST_DOWN;
          // A stop from an expired wait may already hold the first slot.
          if (result_nxt.fx_count == 2'd0) begin
            result_nxt.first_effect = FX_START;
          end else begin
            result_nxt.second_effect = FX_START;
          end
          result_nxt.fx_count = result_nxt.fx_count + 2'd1;
        end
      end
      PH_FIRST_DOWN: begin
        if (release_edge) begin
          if (short_tap) begin
            deadline_nxt = sample.deadline;
            phase_nxt    = PH_WAIT_SECOND;
          end else begin
            phase_nxt               = PH_IDLE;
            result_nxt.fx_count     = 2'd1;
            result_nxt.first_effect = FX_STOP;
          end
        end
      end
      PH_WAIT_SECOND, PH_LK_WAIT_SECOND: begin
        if (press) begin
          press_start_nxt = sample.time_ms;
          phase_nxt = (phase_mid == PH_WAIT_SECOND) ? PH_SECOND_DOWN : PH_LK_SECOND_DOWN;
        end
      end
      PH_SECOND_DOWN: begin
        if (release_edge) begin
          result_nxt.fx_count = 2'd1;
          if (short_tap) begin
            phase_nxt               = PH_LOCKED;
            result_nxt.first_effect = FX_LOCKED;
          end else begin
            phase_nxt               = PH_IDLE;
            result_nxt.first_effect = FX_STOP;
          end
        end
      end
      PH_LOCKED: begin
        if (press) begin
          press_start_nxt = sample.time_ms;
          phase_nxt       = PH_LK_FIRST_DOWN;
        end
      end
      PH_LK_FIRST_DOWN: begin
        if (release_edge) begin
          if (short_tap) begin
            deadline_nxt = sample.deadline;
            phase_nxt    = PH_LK_WAIT_SECOND;
          end else begin
            phase_nxt = PH_LOCKED;
          end
        end
      end
      PH_LK_SECOND_DOWN: begin
        if (release_edge) begin
          if (short_tap) begin
            phase_nxt                = PH_IDLE;
            result_nxt.fx_count      = 2'd2;
            result_nxt.first_effect  = FX_STOP;
            result_nxt.second_effect = FX_UNLOCKED;
          end else begin
            phase_nxt = PH_LOCKED;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    result_nxt.talk_on    = (phase_nxt != PH_IDLE);
    result_nxt.hands_free = (phase_nxt == PH_LOCKED) || (phase_nxt == PH_LK_FIRST_DOWN) ||
                            (phase_nxt == PH_LK_WAIT_SECOND) ||
                            (phase_nxt == PH_LK_SECOND_DOWN);
  end

  // Phase state, timing state and the result register advance together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      last_level_r  <= 1'b0;
      press_start_r <= 64'd0;
      deadline_r    <= 64'd0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      last_level_r  <= sample.button_down;
      press_start_r <= press_start_nxt;
      deadline_r    <= deadline_nxt;
      result_r      <= result_nxt;
    end
  end

  assign result = result_r;

  // Locked talk is always talk.
  `TBG_ASSERT_NOW(a_locked_is_talking, step_en && result_nxt.hands_free, result_nxt.talk_on, "hands-free result without talk")
  // A second effect only ever comes with a count of two.
  `TBG_ASSERT_NOW(a_second_needs_two, step_en && (result_nxt.second_effect != FX_NONE), result_nxt.fx_count == 2'd2, "second effect without count of two")
  // A step that ends idle is not hands-free and leaves the phase idle.
  `TBG_ASSERT_NEXT(a_idle_consistent, step_en && !result_nxt.talk_on, (phase_r == PH_IDLE) && !result_r.hands_free, "idle result disagrees with phase")

endmodule

// ----- hdl/talk_button_gesture_fsm_unit.sv -----
// Top level of the push-to-talk button gesture recognizer.
// A sample is captured in the input register and its result beat is held in the result register.
// One sample per cycle unless out_stall blocks the result register; each sample is resolved combinationally.
// The input register and the result register decouple the two channels.
// Reset (synchronous, rst_n low) clears the phase, the last level and the timers,
// empties both stages and restores tap_max_ms to 300 and the second-tap window to 400.
`include "talk_button_gesture_fsm_unit_defines.svh"

module talk_button_gesture_fsm_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_button_down,
  input  logic [63:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_fx_count,
  output logic [2:0]  out_first_effect,
  output logic [2:0]  out_second_effect,
  output logic        out_talk_on,
  output logic        out_hands_free,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tbg_pkg::*;

  logic [31:0] tap_max_r;
  logic [31:0] window_r;
  logic        cfg_write;

  logic        s1_valid_r;
  sample_t     s1_r;
  logic        out_valid_r;
  logic        advance;
  logic        in_accept;
  result_t     result;

  // Configuration registers; the write lands in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign prdata    = (paddr[2] == REG_SECOND_WINDOW) ? window_r : tap_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_max_r <= TAP_MAX_RESET;
      window_r  <= SECOND_WINDOW_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_TAP_MAX) begin
        tap_max_r <= pwdata;
      end else begin
        window_r <= pwdata;
      end
    end
  end

  // Handshake: the sample stage moves on whenever the result register is empty or its beat is being taken.
  assign advance   = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~advance;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register; the second-tap deadline sum is formed here, wrapping at 64 bits.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r.button_down <= in_button_down;
      s1_r.time_ms     <= in_time_ms;
      s1_r.deadline    <= in_time_ms + {32'd0, window_r};
    end
  end

  tbg_gesture_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .sample     (s1_r),
    .tap_max_ms (tap_max_r),
    .result     (result)
  );

  assign out_valid         = out_valid_r;
  assign out_fx_count      = result.fx_count;
  assign out_first_effect  = result.first_effect;
  assign out_second_effect = result.second_effect;
  assign out_talk_on       = result.talk_on;
  assign out_hands_free    = result.hands_free;

  // A held sample is never dropped while the result register is blocked.
  `TBG_ASSERT_NEXT(a_sample_kept, s1_valid_r && !advance, s1_valid_r, "held sample lost")
  // Every step of the machine produces a result beat.
  `TBG_ASSERT_NEXT(a_step_gives_beat, advance, out_valid_r, "step without result beat")
  // The sample stage only steps into a free or draining result register.
  `TBG_ASSERT_NOW(a_no_overwrite, advance && out_valid_r, !out_stall, "result beat overwritten")

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the push-to-talk button gesture recognizer.
`timescale 1ns / 100ps

module tb_top;
  import tbg_pkg::*;

  // Phases of the gesture machine as tracked by the predictor.
  typedef enum logic [2:0] {
    ST_IDLE         = 3'd0,
    ST_TAP1_DOWN    = 3'd1,
    ST_TAP_GAP      = 3'd2,
    ST_TAP2_DOWN    = 3'd3,
    ST_LOCKED       = 3'd4,
    ST_LK_TAP1_DOWN = 3'd5,
    ST_LK_TAP_GAP   = 3'd6,
    ST_LK_TAP2_DOWN = 3'd7
  } gesture_phase_t;

  // One button sample waiting to be sent.
  typedef struct {
    bit        down;
    bit [63:0] stamp;
  } button_sample_t;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_AFTER_BEATS = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_button_down = 1'b0;
  logic [63:0] in_time_ms = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_fx_count;
  logic [2:0]  out_first_effect;
  logic [2:0]  out_second_effect;
  logic        out_talk_on;
  logic        out_hands_free;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  talk_button_gesture_fsm_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_button_down    (in_button_down),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fx_count      (out_fx_count),
    .out_first_effect  (out_first_effect),
    .out_second_effect (out_second_effect),
    .out_talk_on       (out_talk_on),
    .out_hands_free    (out_hands_free),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Predictor state and its copy of the registers.
  gesture_phase_t gesture_phase = ST_IDLE;
  bit             prev_level = 1'b0;
  bit [63:0]      press_time = 64'd0;
  bit [63:0]      gap_deadline = 64'd0;
  bit [31:0]      tap_limit = TAP_MAX_RESET;
  bit [31:0]      window_len = SECOND_WINDOW_RESET;

  button_sample_t pending_samples[$];
  result_t        expected_results[$];

  // Stimulus generator state.
  bit [63:0] last_stamp = 64'd0;
  bit        level_now = 1'b0;
  int        queued_total = 0;
  bit        burst_mode = 1'b0;

  int             send_gap = 0;
  int             stall_left = 0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;
  int             beats_taken = 0;
  int             beats_checked = 0;
  int             mismatch_count = 0;
  int             quiet_cycles = 0;
  button_sample_t next_sample;
  result_t        want;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one line per mismatch, up to a cap, and count all of them.
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    if (mismatch_count < MAX_PRINTS) begin
      $display("MISMATCH beat %0d: %s got 0x%0h expected 0x%0h",
               beats_checked, what, got, exp_val);
    end
    mismatch_count++;
  endtask

  // Idle length: mostly zero, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A press counts as a tap when it did not run backwards and stayed within the limit.
  function automatic bit is_quick_press(bit [63:0] t);
    return t >= press_time && (t - press_time) <= {32'd0, tap_limit};
  endfunction

  // Advance the gesture machine by one sample and return the result it produces.
  function automatic result_t gesture_step(bit lvl, bit [63:0] t);
    result_t r;
    fx_t     fx[2];
    int      n;
    bit      rise;
    bit      fall;
    rise = lvl && !prev_level;
    fall = !lvl && prev_level;
    prev_level = lvl;
    n = 0;
    fx[0] = FX_NONE;
    fx[1] = FX_NONE;

    // An expired second-tap wait is resolved before any edge.
    if (gesture_phase == ST_TAP_GAP && t >= gap_deadline) begin
      gesture_phase = ST_IDLE;
      fx[n] = FX_STOP;
      n++;
    end else if (gesture_phase == ST_LK_TAP_GAP && t >= gap_deadline) begin
      gesture_phase = ST_LOCKED;
    end

    case (gesture_phase)
      ST_IDLE: begin
        if (rise) begin
          press_time = t;
          gesture_phase = ST_TAP1_DOWN;
          fx[n] = FX_START;
          n++;
        end
      end
      ST_TAP1_DOWN: begin
        if (fall) begin
          if (is_quick_press(t)) begin
            gap_deadline = t + {32'd0, window_len};
            gesture_phase = ST_TAP_GAP;
          end else begin
            gesture_phase = ST_IDLE;
            fx[n] = FX_STOP;
            n++;
          end
        end
      end
      ST_TAP_GAP, ST_LK_TAP_GAP: begin
        if (rise) begin
          press_time = t;
          gesture_phase = (gesture_phase == ST_TAP_GAP) ? ST_TAP2_DOWN : ST_LK_TAP2_DOWN;
        end
      end
      ST_TAP2_DOWN: begin
        if (fall) begin
          if (is_quick_press(t)) begin
            gesture_phase = ST_LOCKED;
            fx[n] = FX_LOCKED;
          end else begin
            gesture_phase = ST_IDLE;
            fx[n] = FX_STOP;
          end
          n++;
        end
      end
      ST_LOCKED: begin
        if (rise) begin
          press_time = t;
          gesture_phase = ST_LK_TAP1_DOWN;
        end
      end
      ST_LK_TAP1_DOWN: begin
        if (fall) begin
          if (is_quick_press(t)) begin
            gap_deadline = t + {32'd0, window_len};
            gesture_phase = ST_LK_TAP_GAP;
          end else begin
            gesture_phase = ST_LOCKED;
          end
        end
      end
      default: begin
        if (fall) begin
          if (is_quick_press(t)) begin
            gesture_phase = ST_IDLE;
            fx[0] = FX_STOP;
            fx[1] = FX_UNLOCKED;
            n = 2;
          end else begin
            gesture_phase = ST_LOCKED;
          end
        end
      end
    endcase

    r.fx_count = n[1:0];
    r.first_effect = fx[0];
    r.second_effect = fx[1];
    r.talk_on = (gesture_phase != ST_IDLE);
    r.hands_free = (gesture_phase >= ST_LOCKED);
    return r;
  endfunction

  // Sample driver: holds a stalled beat, otherwise sends the next sample after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() > 0) begin
        next_sample = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_button_down <= next_sample.down;
        in_time_ms <= next_sample.stamp;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off to back up the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) beats_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && beats_taken >= HOLD_AFTER_BEATS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction, predict on each sample.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", 64'd0, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_fx_count !== want.fx_count)
            report_mismatch("fx_count", out_fx_count, want.fx_count);
          if (out_first_effect !== want.first_effect)
            report_mismatch("first_effect", out_first_effect, want.first_effect);
          if (out_second_effect !== want.second_effect)
            report_mismatch("second_effect", out_second_effect, want.second_effect);
          if (out_talk_on !== want.talk_on)
            report_mismatch("talk_on", out_talk_on, want.talk_on);
          if (out_hands_free !== want.hands_free)
            report_mismatch("hands_free", out_hands_free, want.hands_free);
        end
        beats_checked++;
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(gesture_step(in_button_down, in_time_ms));
      end
    end
  end

  // Watchdog: end the run when no beat and no register access moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_sample(bit lvl, bit [63:0] t);
    button_sample_t s;
    s.down = lvl;
    s.stamp = t;
    pending_samples.push_back(s);
    queued_total++;
    last_stamp = t;
    level_now = lvl;
  endtask

  // Duration clustered around a threshold so both sides of each compare get hit.
  function automatic bit [63:0] duration_near(bit [31:0] lim);
    bit [63:0] l;
    l = {32'd0, lim};
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return l;
      2: return l + 64'd1;
      3: return (lim == 32'd0) ? 64'd0 : l - 64'd1;
      4, 5, 6: return {32'd0, $urandom_range(0, lim)};
      7: return l + 64'($urandom_range(1, 1000));
      default: return 64'($urandom_range(0, 1000));
    endcase
  endfunction

  // Random gestures: mostly level toggles timed near the tap and window limits,
  // with repeated levels, backwards clock steps and wild timestamps mixed in.
  task automatic queue_gestures(int count);
    int goal;
    int pick;
    goal = queued_total + count;
    while (queued_total < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        last_stamp += duration_near(level_now ? tap_limit : window_len);
        queue_sample(!level_now, last_stamp);
      end else if (pick < 88) begin
        last_stamp += duration_near(level_now ? tap_limit : window_len);
        queue_sample(level_now, last_stamp);
      end else if (pick < 95) begin
        last_stamp -= 64'($urandom_range(1, 2000));
        queue_sample(1'($urandom_range(0, 1)), last_stamp);
      end else begin
        queue_sample(1'($urandom_range(0, 1)), {$urandom, $urandom});
      end
    end
  endtask

  // Wait until every sample is sent and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write (setup then access), followed by a read back of the same register.
  task automatic cfg_write(logic idx, logic [31:0] val);
    logic [31:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_TAP_MAX) tap_limit = val;
    else window_len = val;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) begin
      report_mismatch(idx == REG_TAP_MAX ? "tap limit read back" :
                      "tap window read back", rd, val);
    end
  endtask

  task automatic set_config(logic [31:0] tap_val, logic [31:0] window_val);
    wait_drained();
    cfg_write(REG_TAP_MAX, tap_val);
    cfg_write(REG_SECOND_WINDOW, window_val);
    @(negedge clk);
  endtask

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed gestures at the reset limits (tap 300, window 400).
    // Double tap locks, locked tap expires silently, backwards long press stays locked.
    queue_sample(1'b1, 64'd1000);
    queue_sample(1'b0, 64'd1100);
    queue_sample(1'b1, 64'd1200);
    queue_sample(1'b0, 64'd1250);
    queue_sample(1'b1, 64'd2000);
    queue_sample(1'b0, 64'd2050);
    queue_sample(1'b0, 64'd2450);
    queue_sample(1'b1, 64'd2500);
    queue_sample(1'b0, 64'd2400);
    // Locked double tap unlocks with stop and unlocked in one result.
    queue_sample(1'b1, 64'd3000);
    queue_sample(1'b0, 64'd3050);
    queue_sample(1'b1, 64'd3100);
    queue_sample(1'b0, 64'd3150);
    // Press one past the tap limit is a plain talk press.
    queue_sample(1'b1, 64'd4000);
    queue_sample(1'b0, 64'd4301);
    // Press exactly at the limit is a tap; a press at the deadline gives stop then start.
    queue_sample(1'b1, 64'd5000);
    queue_sample(1'b0, 64'd5300);
    queue_sample(1'b1, 64'd5700);
    queue_sample(1'b0, 64'd4000);
    // A backwards sample during the wait does not reach the deadline.
    queue_sample(1'b1, 64'd6000);
    queue_sample(1'b0, 64'd6100);
    queue_sample(1'b0, 64'd10);
    queue_sample(1'b0, 64'd6500);
    // Deadline add wraps past the top of the timestamp range.
    queue_sample(1'b1, 64'hFFFF_FFFF_FFFF_FF9C);
    queue_sample(1'b0, 64'hFFFF_FFFF_FFFF_FFCE);
    queue_sample(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_sample(1'b1, 64'd0);
    queue_sample(1'b0, 64'd0);
    queue_sample(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_gestures(300);

    // Zero limits: only a zero-length press is a tap and the wait ends at the next sample.
    set_config(32'd0, 32'd0);
    queue_sample(1'b0, 64'd100);
    queue_sample(1'b1, 64'd200);
    queue_sample(1'b0, 64'd200);
    queue_sample(1'b0, 64'd200);
    queue_sample(1'b1, 64'd300);
    queue_sample(1'b0, 64'd301);
    queue_gestures(250);

    // Largest limits, sent without any idling.
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    burst_mode = 1'b1;
    queue_gestures(250);
    wait_drained();
    burst_mode = 1'b0;

    set_config(32'd1, 32'd1);
    queue_gestures(250);

    // Random limits, alternating between small and full-range values.
    for (int k = 0; k < 4; k++) begin
      if (k % 2 == 0) set_config($urandom_range(1, 2000), $urandom_range(1, 2000));
      else set_config($urandom, $urandom);
      queue_gestures(220);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
